@@ rtl/lccs_pkg.sv @@
// Shared types and constants for the LED cube frame scanner.
// Used by the voxel store, the scan timer and the top level.
package lccs_pkg;

  // Cube geometry: four layers of 4x4 voxels
  localparam int EDGE       = 4;
  localparam int LAYER_W    = 2;
  localparam int WORD_W     = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int TICK_W     = 8;

  // Request function codes
  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_GET    = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  // Result kind codes
  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_REFRESH = 1'b1;

  // Reset value of the layer dwell time
  localparam logic [TICK_W-1:0] DWELL_TICKS_RST = 8'd2;

  // Decoded request, valid only in the cycle it executes
  typedef struct packed {
    logic set;
    logic get;
    logic commit;
    logic tick;
  } cmd_t;

endpackage

@@ rtl/lccs_voxel_store.sv @@
// Drawing and display buffers of the LED cube frame scanner.
// Depends on lccs_pkg for geometry and the decoded request struct.
module lccs_voxel_store (
  input  logic                                clk,
  input  logic                                rst,
  input  lccs_pkg::cmd_t                      cmd,
  input  logic [lccs_pkg::LAYER_W-1:0]        voxel_layer,
  input  logic [lccs_pkg::BIT_IDX_W-1:0]      voxel_bit,
  input  logic                                voxel_value,
  input  logic [lccs_pkg::LAYER_W-1:0]        scan_layer,
  output logic                                read_bit,
  output logic [lccs_pkg::WORD_W-1:0]         scan_word
);
  import lccs_pkg::*;

  logic [WORD_W-1:0] draw_buffer    [EDGE];
  logic [WORD_W-1:0] display_buffer [EDGE];
  logic [WORD_W-1:0] draw_word;
  logic [WORD_W-1:0] bit_mask;

  // Select the addressed layer word and voxel
  assign draw_word = draw_buffer[voxel_layer];
  assign bit_mask  = WORD_W'(1) << voxel_bit;
  assign read_bit  = draw_word[voxel_bit];
  assign scan_word = display_buffer[scan_layer];

  // Write one voxel, or copy the whole drawing buffer on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EDGE; i++) begin
        draw_buffer[i]    <= '0;
        display_buffer[i] <= '0;
      end
    end else begin
      if (cmd.set) begin
        if (voxel_value) begin
          draw_buffer[voxel_layer] <= draw_word | bit_mask;
        end else begin
          draw_buffer[voxel_layer] <= draw_word & ~bit_mask;
        end
      end
      if (cmd.commit) begin
        for (int i = 0; i < EDGE; i++) begin
          display_buffer[i] <= draw_buffer[i];
        end
      end
    end
  end

endmodule

@@ rtl/lccs_scan_timer.sv @@
// Layer dwell counter and active layer pointer of the LED cube frame scanner.
// Depends on lccs_pkg for widths and the decoded request struct.
module lccs_scan_timer (
  input  logic                            clk,
  input  logic                            rst,
  input  lccs_pkg::cmd_t                  cmd,
  input  logic [lccs_pkg::TICK_W-1:0]     dwell_ticks,
  output logic                            layer_switch,
  output logic [lccs_pkg::LAYER_W-1:0]    next_layer
);
  import lccs_pkg::*;

  logic [LAYER_W-1:0] active_layer;
  logic [TICK_W-1:0]  ticks_since_switch;
  logic [TICK_W-1:0]  ticks_next;

  // Count ticks, saturating at full scale
  assign ticks_next   = (ticks_since_switch == '1) ? ticks_since_switch
                                                   : ticks_since_switch + TICK_W'(1);
  assign layer_switch = (ticks_next >= dwell_ticks);
  assign next_layer   = active_layer + LAYER_W'(1);

  // Advance the layer once the dwell time is reached
  always_ff @(posedge clk) begin
    if (rst) begin
      active_layer       <= '0;
      ticks_since_switch <= '0;
    end else if (cmd.tick) begin
      if (layer_switch) begin
        active_layer       <= next_layer;
        ticks_since_switch <= '0;
      end else begin
        ticks_since_switch <= ticks_next;
      end
    end
  end

endmodule

@@ rtl/led_cube_frame_scanner_unit.sv @@
// LED cube frame scanner: double-buffered 4x4x4 cube with layer scan.
// Instantiates lccs_voxel_store and lccs_scan_timer; depends on lccs_pkg.
//
// Usage:
//   Requests enter on in_valid/in_stall with func, coord_x, coord_y, coord_z
//   and lit. Set writes a voxel of the drawing buffer, get reads it back,
//   commit copies the drawing buffer to the display buffer, tick counts one
//   millisecond. When the ticks since the last switch reach dwell_ticks, the
//   scan moves to the next layer and emits its display word.
//   Results leave on out_valid/out_stall: a read answer (result_kind 0) or a
//   layer refresh (result_kind 1); set, commit and non-switching ticks give
//   no result. dwell_ticks is written through cfg_write_en/cfg_write_data;
//   the user must write it only while idle; the block does not enforce it.
// Timing:
//   A request is captured in the input register, then executes when the result
//   register can take it, writing the result register; for a read or a layer
//   switch, out_valid rises with that write.
//   One request per cycle is sustained while out_stall does not hold a result;
//   every request is one pass through the buffer and counter logic.
// Reset and stall:
//   rst clears both buffers, the layer pointer and the tick count, and sets
//   dwell_ticks to 2. While out_stall holds a result, the held request waits
//   in the input register and in_stall rises once that register is full.
module led_cube_frame_scanner_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic [1:0]                        coord_x,
  input  logic [1:0]                        coord_y,
  input  logic [1:0]                        coord_z,
  input  logic                              lit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              result_kind,
  output logic                              voxel_lit,
  output logic [lccs_pkg::LAYER_W-1:0]      layer_index,
  output logic [lccs_pkg::WORD_W-1:0]       layer_word,
  input  logic                              cfg_write_en,
  input  logic [lccs_pkg::TICK_W-1:0]       cfg_write_data
);
  import lccs_pkg::*;

  logic               req_valid;
  logic [1:0]         req_func;
  logic [1:0]         req_x;
  logic [1:0]         req_y;
  logic [1:0]         req_z;
  logic               req_lit;
  logic [TICK_W-1:0]  dwell_ticks;
  logic               advance;
  cmd_t               cmd;
  logic               read_bit;
  logic [WORD_W-1:0]  scan_word;
  logic               layer_switch;
  logic [LAYER_W-1:0] next_layer;
  logic               emit;

  // Execute the held request when the result register can take it
  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;

  // Decode the held request into single-cycle strobes
  always_comb begin
    cmd = '0;
    if (req_valid && advance) begin
      case (req_func)
        FUNC_SET:    cmd.set    = 1'b1;
        FUNC_GET:    cmd.get    = 1'b1;
        FUNC_COMMIT: cmd.commit = 1'b1;
        FUNC_TICK:   cmd.tick   = 1'b1;
        default:     cmd        = '0;
      endcase
    end
  end

  assign emit = cmd.get || (cmd.tick && layer_switch);

  // Hold the dwell time register
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= DWELL_TICKS_RST;
    end else if (cfg_write_en) begin
      dwell_ticks <= cfg_write_data;
    end
  end

  // Capture an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_func <= func;
      req_x    <= coord_x;
      req_y    <= coord_y;
      req_z    <= coord_z;
      req_lit  <= lit;
    end
  end

  lccs_voxel_store u_voxel_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .voxel_layer (req_z),
    .voxel_bit   ({req_y, req_x}),
    .voxel_value (req_lit),
    .scan_layer  (next_layer),
    .read_bit    (read_bit),
    .scan_word   (scan_word)
  );

  lccs_scan_timer u_scan_timer (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .dwell_ticks  (dwell_ticks),
    .layer_switch (layer_switch),
    .next_layer   (next_layer)
  );

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      if (cmd.get) begin
        result_kind <= KIND_READ;
        voxel_lit   <= read_bit;
        layer_index <= '0;
        layer_word  <= '0;
      end else begin
        result_kind <= KIND_REFRESH;
        voxel_lit   <= 1'b0;
        layer_index <= next_layer;
        layer_word  <= scan_word;
      end
    end
  end

endmodule

@@ bench/tb_led_cube_frame_scanner_unit.sv @@
// Self-checking bench for led_cube_frame_scanner_unit: directed probes, then random
// requests over several dwell settings, checked against an in-bench cube model.
// Depends on lccs_pkg and the scanner top level only.
`timescale 1ns / 100ps

module tb_led_cube_frame_scanner_unit;
  import lccs_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_PHASES      = 8;

  typedef struct packed {
    logic              kind;
    logic              voxel;
    logic [LAYER_W-1:0] layer;
    logic [WORD_W-1:0]  word;
  } scan_result_t;

  typedef struct packed {
    logic [1:0]   f;
    logic [1:0]   x;
    logic [1:0]   y;
    logic [1:0]   z;
    logic         l;
    logic         typed;
    scan_result_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = FUNC_SET;
  logic [1:0]         coord_x = '0;
  logic [1:0]         coord_y = '0;
  logic [1:0]         coord_z = '0;
  logic               lit = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               result_kind;
  logic               voxel_lit;
  logic [LAYER_W-1:0] layer_index;
  logic [WORD_W-1:0]  layer_word;
  logic               cfg_write_en = 1'b0;
  logic [TICK_W-1:0]  cfg_write_data = '0;

  // Cube model state
  logic [EDGE-1:0][WORD_W-1:0] draw_img;
  logic [EDGE-1:0][WORD_W-1:0] show_img;
  logic [LAYER_W-1:0]          scan_layer;
  logic [TICK_W-1:0]           tick_count;
  logic [TICK_W-1:0]           dwell;

  scan_result_t owed_outputs[$];
  probe_row_t   probe_rows[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  reads_seen = 0;
  int  refreshes_seen = 0;
  int  held_off_cycles = 0;
  int  cycle_count = 0;
  int  tx_idle_rate = 4;
  int  rx_idle_rate = 4;
  bit  hold_off_armed = 1'b0;

  led_cube_frame_scanner_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .lit            (lit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .voxel_lit      (voxel_lit),
    .layer_index    (layer_index),
    .layer_word     (layer_word),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, owed_outputs.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Advance the cube model by one request
  task automatic cube_apply(input logic [1:0] f, input logic [1:0] x, input logic [1:0] y,
                            input logic [1:0] z, input logic l,
                            output bit has, output scan_result_t res);
    logic [3:0] pos;
    pos = {y, x};
    has = 1'b0;
    res = '0;
    case (f)
      FUNC_SET: begin
        draw_img[z][pos] = l;
      end
      FUNC_GET: begin
        has = 1'b1;
        res.kind = KIND_READ;
        res.voxel = draw_img[z][pos];
      end
      FUNC_COMMIT: begin
        show_img = draw_img;
      end
      default: begin
        if (tick_count != 8'hFF) tick_count = tick_count + 8'd1;
        if (tick_count >= dwell) begin
          scan_layer = scan_layer + 2'd1;
          tick_count = '0;
          has = 1'b1;
          res.kind = KIND_REFRESH;
          res.layer = scan_layer;
          res.word = show_img[scan_layer];
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input scan_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at cycle %0d: %s; expected kind=%0d lit=%0d layer=%0d word=%04h",
               cycle_count, what, want.kind, want.voxel, want.layer, want.word);
      $display("  got kind=%0d lit=%0d layer=%0d word=%04h",
               result_kind, voxel_lit, layer_index, layer_word);
    end
  endtask

  task automatic add_probe(input logic [1:0] f, input logic [1:0] x, input logic [1:0] y,
                           input logic [1:0] z, input logic l, input logic typed,
                           input logic k, input logic v, input logic [1:0] ly,
                           input logic [15:0] w);
    probe_row_t row;
    row.f = f;
    row.x = x;
    row.y = y;
    row.z = z;
    row.l = l;
    row.typed = typed;
    row.want = {k, v, ly, w};
    probe_rows.push_back(row);
  endtask

  // Offer one request, hold it until taken, then log what it owes
  task automatic offer_request(input logic [1:0] f, input logic [1:0] x, input logic [1:0] y,
                               input logic [1:0] z, input logic l, input logic typed,
                               input scan_result_t want);
    bit           taken;
    bit           has;
    scan_result_t res;
    if (tx_idle_rate != 0 && $urandom_range(0, 15) < tx_idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    lit <= l;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    requests_sent++;
    cube_apply(f, x, y, z, l, has, res);
    if (typed) owed_outputs.push_back(want);
    else if (has) owed_outputs.push_back(res);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic drain_block();
    in_valid <= 1'b0;
    while (owed_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dwell_ticks(input logic [TICK_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dwell = value;
  endtask

  // Receiver pacing: random stall bursts, one long hold-off on request
  initial begin : rx_pacing
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_rate != 0 && $urandom_range(0, 15) < rx_idle_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Count cycles where the block pushes back on the sender
  always @(negedge clk) begin
    if (!rst && in_valid && in_stall) held_off_cycles++;
  end

  // Check each taken result against the oldest owed one
  always @(negedge clk) begin : result_check
    scan_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (result_kind === KIND_READ) reads_seen++;
      else refreshes_seen++;
      if (owed_outputs.size() == 0) begin
        note_mismatch("result with nothing owed", '0);
      end else begin
        want = owed_outputs.pop_front();
        if (result_kind !== want.kind || voxel_lit !== want.voxel ||
            layer_index !== want.layer || layer_word !== want.word)
          note_mismatch("field differs", want);
      end
    end
  end

  initial begin : stimulus
    scan_result_t none;
    logic [1:0]   f;
    int           pick;
    int           count;
    int           tick_pct;
    logic [7:0]   setting;

    none = '0;
    draw_img = '0;
    show_img = '0;
    scan_layer = '0;
    tick_count = '0;
    dwell = DWELL_TICKS_RST;

    // Directed probes, reset dwell of 2
    add_probe(FUNC_GET,    0, 0, 0, 0, 1, KIND_READ,    0, 0, 16'h0000);
    add_probe(FUNC_GET,    3, 3, 3, 1, 1, KIND_READ,    0, 0, 16'h0000);
    add_probe(FUNC_SET,    3, 3, 3, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_GET,    3, 3, 3, 0, 1, KIND_READ,    1, 0, 16'h0000);
    add_probe(FUNC_SET,    0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_SET,    3, 0, 2, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_SET,    0, 3, 1, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   1, 2, 3, 1, 1, KIND_REFRESH, 0, 1, 16'h0000);
    add_probe(FUNC_COMMIT, 2, 1, 0, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   3, 3, 3, 1, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 1, KIND_REFRESH, 0, 2, 16'h0008);
    add_probe(FUNC_SET,    3, 3, 3, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_GET,    3, 3, 3, 1, 1, KIND_READ,    0, 0, 16'h0000);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 1, KIND_REFRESH, 0, 3, 16'h8000);
    add_probe(FUNC_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 1, KIND_REFRESH, 0, 0, 16'h0001);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_probe(FUNC_TICK,   0, 0, 0, 0, 1, KIND_REFRESH, 0, 1, 16'h1000);
    add_probe(FUNC_GET,    0, 3, 1, 0, 1, KIND_READ,    1, 0, 16'h0000);
    add_probe(FUNC_GET,    2, 1, 0, 0, 0, 0, 0, 0, 0);

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[i])
      offer_request(probe_rows[i].f, probe_rows[i].x, probe_rows[i].y, probe_rows[i].z,
                    probe_rows[i].l, probe_rows[i].typed, probe_rows[i].want);

    // Random phases, each under its own dwell setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      count = 220;
      tick_pct = 40;
      tx_idle_rate = $urandom_range(0, 6);
      rx_idle_rate = $urandom_range(0, 6);
      case (p)
        0: begin setting = 8'd0;   tick_pct = 30; tx_idle_rate = 1; end
        1: begin setting = 8'd255; count = 380; tick_pct = 85; end
        2: begin setting = 8'd1;   tick_pct = 30; end
        3: begin setting = 8'd3;   rx_idle_rate = 0; tx_idle_rate = 8; end
        4: begin setting = 8'($urandom_range(4, 20)); tick_pct = 60; end
        5: begin setting = 8'($urandom_range(0, 255)); tick_pct = 50; end
        6: begin setting = 8'd2;   tx_idle_rate = 0; rx_idle_rate = 8; end
        default: begin
          setting = 8'($urandom_range(0, 7));
          tx_idle_rate = 0;
          rx_idle_rate = 0;
        end
      endcase
      drain_block();
      write_dwell_ticks(setting);
      // In phase 0, fill the block while the receiver holds off
      if (p == 0) hold_off_armed = 1'b1;
      repeat (count) begin
        pick = $urandom_range(0, 99);
        if (pick < tick_pct) f = FUNC_TICK;
        else begin
          pick = $urandom_range(0, 99);
          if (pick < 45) f = FUNC_SET;
          else if (pick < 85) f = FUNC_GET;
          else f = FUNC_COMMIT;
        end
        offer_request(f, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, none);
      end
    end

    // Wait out the tail, then look for stray results
    drain_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_outputs.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", owed_outputs.size());
    end

    $display("run covered %0d requests: %0d read answers, %0d layer refreshes",
             requests_sent, reads_seen, refreshes_seen);
    $display("dwell swept 2, 0, 255, 1, 3 and random; input pushed back on %0d cycles",
             held_off_cycles);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
